// ===== src/trimmed_mean_rtt_clock_offset_top_defines.svh =====
// assertion macros for the port-level checks of the offset estimator
`ifndef TRIMMED_MEAN_RTT_CLOCK_OFFSET_TOP_DEFINES_SVH
`define TRIMMED_MEAN_RTT_CLOCK_OFFSET_TOP_DEFINES_SVH

// same-cycle implication, no reset gating
`define TMRC_ASSERT_NOW(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("tmrc assertion failed");

// next-cycle implication, no reset gating
`define TMRC_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("tmrc assertion failed");

// next-cycle implication, disabled while reset is high
`define TMRC_ASSERT_NEXT_RST(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tmrc assertion failed");

`endif

// ===== src/tmrc_pkg.sv =====
// shared constants, types and state encoding of the offset estimator
package tmrc_pkg;

   localparam int DATA_W      = 32;
   localparam int DEF_WINDOW  = 8;
   localparam int DEF_TRIM    = 1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD_I,
      ST_PIVOT,
      ST_SCAN,
      ST_DRAIN,
      ST_ACCUM,
      ST_DIV_LOAD,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic pivot_load;
      logic rank_clear;
      logic cmp;
      logic accum;
      logic div_load;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic will_be_full;
      logic out_free;
   } status_type;

endpackage

// ===== src/tmrc_if.sv =====
// valid/ready channel interfaces for time responses and offset results
interface tmrc_req_if;
   import tmrc_pkg::*;
   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   local_now_ms;
   logic [DATA_W-1:0]   sent_time_ms;
   logic [DATA_W-1:0]   server_time_ms;

   modport source (output valid, local_now_ms, sent_time_ms, server_time_ms, input ready);
   modport sink (input valid, local_now_ms, sent_time_ms, server_time_ms, output ready);
endinterface

interface tmrc_rsp_if;
   import tmrc_pkg::*;
   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   server_delta_ms;
   logic [DATA_W-1:0]   mean_rtt_ms;
   logic                window_full;

   modport source (output valid, server_delta_ms, mean_rtt_ms, window_full, input ready);
   modport sink (input valid, server_delta_ms, mean_rtt_ms, window_full, output ready);
endinterface

// ===== src/tmrc_ctrl.sv =====
// sequencer: rank scan over the window, reciprocal divide, result hand-off
module tmrc_ctrl #(
   parameter int WINDOW        = tmrc_pkg::DEF_WINDOW,
   parameter int TRIM_PER_SIDE = tmrc_pkg::DEF_TRIM
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  tmrc_pkg::status_type          status,
   output tmrc_pkg::cmd_type             cmd,
   output logic [$clog2(WINDOW)-1:0]     rd_addr,
   output logic [$clog2(WINDOW)-1:0]     pivot_idx
);
   import tmrc_pkg::*;

   localparam int  IDX_W     = $clog2(WINDOW);
   localparam int  SUM_W     = DATA_W + $clog2(WINDOW);
   localparam bit  KEPT_ZERO = (2 * TRIM_PER_SIDE >= WINDOW);
   localparam int  KEPT_NZ   = KEPT_ZERO ? 1 : WINDOW - 2 * TRIM_PER_SIDE;
   // one step per 16-bit slice of the reciprocal
   localparam int  MUL_STEPS = (SUM_W + $clog2(KEPT_NZ) + 16) / 16;
   localparam int  CNT_W     = $clog2(MUL_STEPS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MUL_STEPS - 1);

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff   <= i_in;
      j_ff   <= j_in;
      cnt_ff <= cnt_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (status.will_be_full && !KEPT_ZERO) ? ST_LOAD_I : ST_FINISH;
            end
         end
         ST_LOAD_I:   state_in = ST_PIVOT;
         ST_PIVOT:    state_in = ST_SCAN;
         ST_SCAN: begin
            if (j_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:    state_in = ST_ACCUM;
         ST_ACCUM:    state_in = (i_ff == LAST_IDX) ? ST_DIV_LOAD : ST_LOAD_I;
         ST_DIV_LOAD: state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == LAST_CNT) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // commands and counters
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rd_addr   = i_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      cnt_in    = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            i_in       = '0;
         end
         ST_LOAD_I: begin
            rd_addr = i_ff;
         end
         ST_PIVOT: begin
            cmd.pivot_load = 1'b1;
            cmd.rank_clear = 1'b1;
            cmd.cmp        = 1'b1;
            rd_addr        = '0;
            j_in           = IDX_W'(1);
         end
         ST_SCAN: begin
            cmd.cmp = 1'b1;
            rd_addr = j_ff;
            j_in    = j_ff + IDX_W'(1);
         end
         ST_DRAIN: begin
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            i_in      = i_ff + IDX_W'(1);
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
         end
         ST_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: begin
         end
      endcase
   end

   assign pivot_idx = i_ff;

endmodule

// ===== src/tmrc_dp.sv =====
// datapath: rtt ring memory, rank counter, trimmed sum, divider, result registers
module tmrc_dp #(
   parameter int WINDOW        = tmrc_pkg::DEF_WINDOW,
   parameter int TRIM_PER_SIDE = tmrc_pkg::DEF_TRIM
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [tmrc_pkg::DATA_W-1:0]       local_now_ms,
   input  logic [tmrc_pkg::DATA_W-1:0]       sent_time_ms,
   input  logic [tmrc_pkg::DATA_W-1:0]       server_time_ms,
   input  tmrc_pkg::cmd_type                 cmd,
   input  logic [$clog2(WINDOW)-1:0]         rd_addr,
   input  logic [$clog2(WINDOW)-1:0]         pivot_idx,
   output tmrc_pkg::status_type              status,
   tmrc_rsp_if.source                        rsp_if
);
   import tmrc_pkg::*;

   localparam int  IDX_W     = $clog2(WINDOW);
   localparam int  FILL_W    = $clog2(WINDOW + 1);
   localparam int  SUM_W     = DATA_W + $clog2(WINDOW);
   localparam bit  KEPT_ZERO = (2 * TRIM_PER_SIDE >= WINDOW);
   localparam int  KEPT_NZ   = KEPT_ZERO ? 1 : WINDOW - 2 * TRIM_PER_SIDE;
   localparam int  CW        = $clog2(WINDOW + TRIM_PER_SIDE + 1);
   localparam int  HI_INT    = KEPT_ZERO ? 0 : WINDOW - TRIM_PER_SIDE;
   // floor(sum / kept) = floor(sum * RECIP / 2^SH) for every sum below 2^SUM_W
   localparam int  SH        = SUM_W + $clog2(KEPT_NZ);
   localparam int  MUL_STEPS = (SH + 16) / 16;
   localparam int  RW        = 16 * MUL_STEPS;
   localparam int  ACC_W     = SUM_W + 16;
   localparam int  QSH       = SH - 16 * (MUL_STEPS - 1);
   localparam logic [63:0]       RECIP_64 = ((64'd1 << SH) + 64'(KEPT_NZ - 1)) / 64'(KEPT_NZ);
   localparam logic [RW-1:0]     RECIP    = RW'(RECIP_64);
   localparam logic [CW-1:0]     RANK_LO  = CW'(TRIM_PER_SIDE);
   localparam logic [CW-1:0]     RANK_HI  = CW'(HI_INT);
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(WINDOW - 1);
   localparam logic [FILL_W-1:0] FULL_M1  = FILL_W'(WINDOW - 1);
   localparam logic [FILL_W-1:0] FULL_CNT = FILL_W'(WINDOW);

   logic [DATA_W-1:0]  mem [WINDOW];

   logic [IDX_W-1:0]   slot_ff;
   logic [FILL_W-1:0]  fill_ff;
   logic [DATA_W-1:0]  rd_data_ff;
   logic               cmp_ff;
   logic [IDX_W-1:0]   cmp_idx_ff;
   logic [DATA_W-1:0]  pivot_ff;
   logic [IDX_W-1:0]   pivot_idx_ff;
   logic [IDX_W-1:0]   rank_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [RW-1:0]      recip_ff;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [DATA_W-1:0]  rtt_ff;
   logic [DATA_W-1:0]  base_ff;
   logic               full_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  delta_ff, delta_in;
   logic [DATA_W-1:0]  mean_ff, mean_in;
   logic               wfull_ff;

   logic [DATA_W-1:0]  rtt;
   logic               below;
   logic               keep;
   logic [ACC_W-1:0]   partial;

   assign rtt = local_now_ms - sent_time_ms;

   assign status.will_be_full = (fill_ff >= FULL_M1);
   assign status.out_free     = !rsp_valid_ff || rsp_if.ready;

   // stable rank: smaller value, or equal value at a lower slot
   assign below = (rd_data_ff < pivot_ff) ||
                  ((rd_data_ff == pivot_ff) && (cmp_idx_ff < pivot_idx_ff));
   assign keep  = ({{(CW-IDX_W){1'b0}}, rank_ff} >= RANK_LO) &&
                  ({{(CW-IDX_W){1'b0}}, rank_ff} <  RANK_HI);

   // reciprocal multiply, low 16-bit slice first, dropping 16 low bits per step
   assign partial = ACC_W'(sum_ff) * ACC_W'(recip_ff[15:0]);
   assign acc_in  = (acc_ff >> 16) + partial;

   always_comb begin
      if (!full_ff) begin
         mean_in = rtt_ff;
      end else if (KEPT_ZERO) begin
         mean_in = '0;
      end else begin
         mean_in = acc_ff[QSH +: DATA_W];
      end
      delta_in = base_ff - {1'b0, mean_in[DATA_W-1:1]};
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mem[slot_ff] <= rtt;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         fill_ff      <= '0;
         cmp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmp_ff       <= cmd.cmp;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.accept) begin
            slot_ff <= (slot_ff == LAST_IDX) ? '0 : slot_ff + IDX_W'(1);
            if (fill_ff != FULL_CNT) begin
               fill_ff <= fill_ff + FILL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= rd_addr;
      if (cmd.accept) begin
         rtt_ff  <= rtt;
         base_ff <= server_time_ms - sent_time_ms;
         full_ff <= status.will_be_full;
         sum_ff  <= '0;
      end
      if (cmd.pivot_load) begin
         pivot_ff     <= rd_data_ff;
         pivot_idx_ff <= pivot_idx;
      end
      if (cmd.rank_clear) begin
         rank_ff <= '0;
      end else if (cmp_ff && below) begin
         rank_ff <= rank_ff + IDX_W'(1);
      end
      if (cmd.accum && keep) begin
         sum_ff <= sum_ff + {{(SUM_W-DATA_W){1'b0}}, pivot_ff};
      end
      if (cmd.div_load) begin
         recip_ff <= RECIP;
         acc_ff   <= '0;
      end else if (cmd.div_step) begin
         recip_ff <= recip_ff >> 16;
         acc_ff   <= acc_in;
      end
      if (cmd.finish) begin
         delta_ff <= delta_in;
         mean_ff  <= mean_in;
         wfull_ff <= full_ff;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.server_delta_ms = delta_ff;
   assign rsp_if.mean_rtt_ms     = mean_ff;
   assign rsp_if.window_full     = wfull_ff;

endmodule

// ===== src/trimmed_mean_rtt_clock_offset_top.sv =====
// Trimmed-mean RTT clock offset estimator, top level.
// req_if carries one time response per transfer: local arrival time, echoed
// send time and server time, all in ms. rsp_if returns one result per
// response: server_delta_ms, mean_rtt_ms and window_full.
// The block takes one response at a time; req_if.ready is high only while
// it is idle. While the RTT window is not yet full the result goes straight
// to the output register. Once full, every slot is ranked against all others
// through the single read port of the window memory, then the kept sum is
// divided by a reciprocal multiply that takes 16 bits of the reciprocal per
// cycle before the result goes to the output register. With all entries
// trimmed, the mean of a full window is 0 and the rank scan and the divide
// are skipped.
// The result sits in an output register: a new response is accepted while
// it waits, but that response's result holds back until rsp_if.ready takes
// the previous one. Synchronous reset empties the window and drops any
// pending result; window contents are not cleared.
module trimmed_mean_rtt_clock_offset_top #(
   parameter int WINDOW        = tmrc_pkg::DEF_WINDOW,
   parameter int TRIM_PER_SIDE = tmrc_pkg::DEF_TRIM
) (
   input  logic         clock,
   input  logic         reset,
   tmrc_req_if.sink     req_if,
   tmrc_rsp_if.source   rsp_if
);
   import tmrc_pkg::*;

   localparam int IDX_W = $clog2(WINDOW);

   cmd_type            cmd;
   status_type         status;
   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   pivot_idx;
   logic               req_ready;

   assign req_if.ready = req_ready;

   tmrc_ctrl #(
      .WINDOW        (WINDOW),
      .TRIM_PER_SIDE (TRIM_PER_SIDE)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .pivot_idx (pivot_idx)
   );

   tmrc_dp #(
      .WINDOW        (WINDOW),
      .TRIM_PER_SIDE (TRIM_PER_SIDE)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .local_now_ms   (req_if.local_now_ms),
      .sent_time_ms   (req_if.sent_time_ms),
      .server_time_ms (req_if.server_time_ms),
      .cmd            (cmd),
      .rd_addr        (rd_addr),
      .pivot_idx      (pivot_idx),
      .status         (status),
      .rsp_if         (rsp_if)
   );

endmodule

// ===== src/tmrc_chk.sv =====
// port-level checks of the offset estimator, bound to the top level
`include "trimmed_mean_rtt_clock_offset_top_defines.svh"

module tmrc_chk (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [tmrc_pkg::DATA_W-1:0]   rsp_delta,
   input  logic [tmrc_pkg::DATA_W-1:0]   rsp_mean,
   input  logic                          rsp_full
);

   // reset leaves the block idle with nothing to deliver
   `TMRC_ASSERT_NEXT(a_reset_idle, clock, reset, req_ready && !rsp_valid)

   // one response in flight: a transfer closes the input for the next cycle
   `TMRC_ASSERT_NEXT_RST(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)

   // stalled result keeps valid
   `TMRC_ASSERT_NEXT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // stalled result keeps its payload
   `TMRC_ASSERT_NEXT_RST(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready,
      $stable(rsp_delta) && $stable(rsp_mean) && $stable(rsp_full))

endmodule

bind trimmed_mean_rtt_clock_offset_top tmrc_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_delta (rsp_if.server_delta_ms),
   .rsp_mean  (rsp_if.mean_rtt_ms),
   .rsp_full  (rsp_if.window_full)
);
